@@ hdl/vrm_pkg.sv @@
// Shared types and constants for the voxel ray march unit.
// Used by the controller, the datapath and the top level; no dependencies.
package vrm_pkg;

   // Default grid edge and fixed-point format.
   localparam int GRID_SIZE_DEF = 64;
   localparam int FRAC_BITS     = 16;

   // Field widths of the request and the response.
   localparam int COORD_W    = 6;
   localparam int KIND_W     = 2;
   localparam int IN_W       = 22;
   localparam int DIST_W     = 21;
   localparam int REQ_DATA_W = 160;
   localparam int RSP_DATA_W = 48;

   // Internal widths: ray length, crossing numerators, cell coordinates.
   localparam int LEN_W  = 22;
   localparam int N_W    = 23;
   localparam int CELL_W = 10;
   localparam int SQ_W   = 2 * LEN_W;
   localparam int CNT_W  = $clog2(LEN_W);

   // Request kinds and voxel kinds.
   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_MARCH = 1'b1;
   localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd0;
   localparam logic [KIND_W-1:0] KIND_WATER = 2'd1;
   localparam logic [KIND_W-1:0] KIND_LAVA  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_SOLID = 2'd3;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_DECODE, ST_WRITE, ST_SQ1, ST_SQ2, ST_SQ3, ST_SQRT,
      ST_NCALC, ST_CMP, ST_SHORT, ST_UPDATE, ST_READ, ST_EXAM, ST_FIN, ST_DIV_INIT,
      ST_DIV, ST_RESP
   } state_type;

   // Operand selection of the two shared multipliers.
   typedef enum logic [2:0] {
      MUL_NONE, MUL_SQ01, MUL_SQ2, MUL_P01, MUL_P02, MUL_P12, MUL_SHORT, MUL_DIST
   } mul_sel_type;

   // Axis pair whose crossing comparison is stored.
   typedef enum logic [1:0] {
      PAIR_01, PAIR_02, PAIR_12
   } pair_type;

   typedef struct packed {
      logic        clear_step;
      logic        load;
      logic        wr_voxel;
      logic        sq_first;
      logic        sq_add;
      logic        sqrt_step;
      logic        ncalc;
      mul_sel_type mul_sel;
      logic        cmp_en;
      pair_type    cmp_pair;
      logic        update;
      logic        examine;
      logic        dist_len;
      logic        div_init;
      logic        div_step;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic is_march;
      logic any_mov;
      logic solid;
      logic step_end;
      logic hit;
      logic dist_full;
      logic rsp_busy;
   } sts_type;

endpackage

@@ hdl/vrm_ctrl.sv @@
// Sequencing state machine of the voxel ray march unit.
// Depends on vrm_pkg; drives the datapath through cmd_type and reads sts_type.
module vrm_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  vrm_pkg::sts_type sts,
   output vrm_pkg::cmd_type cmd
);
   import vrm_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // State and step counter registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff + CNT_W'(1);
      case (state_ff)
         ST_CLEAR: begin
            if (sts.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            if (!sts.is_march) state_in = ST_WRITE;
            else if (!sts.any_mov) state_in = ST_RESP;
            else state_in = ST_SQ1;
         end
         ST_WRITE: state_in = ST_RESP;
         ST_SQ1:   state_in = ST_SQ2;
         ST_SQ2:   state_in = ST_SQ3;
         ST_SQ3: begin
            state_in = ST_SQRT;
            cnt_in   = '0;
         end
         ST_SQRT: begin
            if (cnt_ff == CNT_W'(LEN_W - 1)) state_in = ST_NCALC;
         end
         ST_NCALC: begin
            state_in = ST_CMP;
            cnt_in   = '0;
         end
         ST_CMP: begin
            if (cnt_ff == CNT_W'(3)) state_in = ST_SHORT;
         end
         ST_SHORT:  state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_READ;
         ST_READ:   state_in = ST_EXAM;
         ST_EXAM: begin
            if (sts.solid || sts.step_end) state_in = ST_FIN;
            else state_in = ST_NCALC;
         end
         ST_FIN: begin
            if (!sts.hit || sts.dist_full) state_in = ST_RESP;
            else state_in = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            state_in = ST_DIV;
            cnt_in   = '0;
         end
         ST_DIV: begin
            if (cnt_ff == CNT_W'(LEN_W - 1)) state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!sts.rsp_busy) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_CLEAR: cmd.clear_step = 1'b1;
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_WRITE: cmd.wr_voxel = 1'b1;
         ST_SQ1:   cmd.mul_sel = MUL_SQ01;
         ST_SQ2: begin
            cmd.mul_sel  = MUL_SQ2;
            cmd.sq_first = 1'b1;
         end
         ST_SQ3:   cmd.sq_add = 1'b1;
         ST_SQRT:  cmd.sqrt_step = 1'b1;
         ST_NCALC: cmd.ncalc = 1'b1;
         ST_CMP: begin
            // Products of one pair are compared the cycle after they are formed.
            case (cnt_ff)
               CNT_W'(0): cmd.mul_sel = MUL_P01;
               CNT_W'(1): begin
                  cmd.mul_sel  = MUL_P02;
                  cmd.cmp_en   = 1'b1;
                  cmd.cmp_pair = PAIR_01;
               end
               CNT_W'(2): begin
                  cmd.mul_sel  = MUL_P12;
                  cmd.cmp_en   = 1'b1;
                  cmd.cmp_pair = PAIR_02;
               end
               default: begin
                  cmd.cmp_en   = 1'b1;
                  cmd.cmp_pair = PAIR_12;
               end
            endcase
         end
         ST_SHORT:  cmd.mul_sel = MUL_SHORT;
         ST_UPDATE: cmd.update = 1'b1;
         ST_EXAM:   cmd.examine = 1'b1;
         ST_FIN: begin
            if (!sts.hit || sts.dist_full) cmd.dist_len = 1'b1;
            else cmd.mul_sel = MUL_DIST;
         end
         ST_DIV_INIT: cmd.div_init = 1'b1;
         ST_DIV:      cmd.div_step = 1'b1;
         ST_RESP:     cmd.out_load = !sts.rsp_busy;
         default: ;
      endcase
   end

endmodule

@@ hdl/vrm_datapath.sv @@
// Datapath of the voxel ray march unit: voxel store, multipliers, square
// root and divider steps, cell stepping and the response register. Uses vrm_pkg.
module vrm_datapath #(
   parameter int GRID_SIZE = vrm_pkg::GRID_SIZE_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [vrm_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                               req_tuser,
   input  vrm_pkg::cmd_type                   cmd,
   output vrm_pkg::sts_type                   sts,
   input  logic                               rsp_tready,
   output logic                               rsp_tvalid,
   output logic [vrm_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                               rsp_tuser
);
   import vrm_pkg::*;

   localparam int CW    = $clog2(GRID_SIZE);
   localparam int AW    = 3 * CW;
   localparam int DEPTH = 1 << AW;
   localparam int SR_W  = LEN_W + 3;
   localparam int P_W   = 2 * N_W;

   // Request field offsets inside tdata.
   localparam int OFS_X    = 0;
   localparam int OFS_Y    = OFS_X + COORD_W;
   localparam int OFS_Z    = OFS_Y + COORD_W;
   localparam int OFS_KIND = OFS_Z + COORD_W;
   localparam int OFS_O    = OFS_KIND + KIND_W;
   localparam int OFS_V    = OFS_O + 3 * IN_W;
   localparam int OFS_LIQ  = OFS_V + 3 * IN_W;

   // Request registers.
   logic                    func_ff;
   logic [COORD_W-1:0]      wx_ff, wy_ff, wz_ff;
   logic [KIND_W-1:0]       wkind_ff;
   logic [IN_W-1:0]         o_ff [3];
   logic [IN_W-1:0]         d_ff [3];
   logic                    neg_ff [3];
   logic                    mov_ff [3];

   // March state.
   logic signed [CELL_W-1:0] cell_ff [3];
   logic signed [CELL_W-1:0] bnd_ff [3];
   logic [N_W-1:0]          n_ff [3];
   logic [SQ_W-1:0]         sq_ff;
   logic [LEN_W-1:0]        len_ff;
   logic [SR_W-1:0]         srem_ff;
   logic [P_W-1:0]          p_ff, q_ff;
   logic                    lt_ff [3];
   logic                    eq_ff [3];
   logic [N_W-1:0]          sn_ff, ssum_ff;
   logic [IN_W-1:0]         sd_ff;
   logic                    end_ff;
   logic [KIND_W-1:0]       rd_ff;
   logic                    inb_ff;
   logic                    liq_ff, lava_ff, hit_ff;
   logic [LEN_W-1:0]        dist_ff;
   logic [N_W:0]            drem_ff;
   logic [LEN_W-1:0]        dlo_ff;
   logic [AW-1:0]           clr_addr_ff;

   // Response register.
   logic                    rsp_valid_ff;
   logic [RSP_DATA_W-1:0]   rsp_data_ff;
   logic                    rsp_user_ff;

   logic [KIND_W-1:0]       mem_q [DEPTH];

   // Combinational helpers.
   logic [IN_W-1:0]         v_req [3];
   logic [IN_W-1:0]         o_req [3];
   logic [N_W-1:0]          ma, mb, mc, md;
   logic [1:0]              a_idx;
   logic                    tie [3];
   logic [N_W-1:0]          na;
   logic [IN_W-1:0]         da;
   logic                    shortray;
   logic signed [CELL_W-1:0] cell_upd [3];
   logic signed [CELL_W-1:0] bnd_upd [3];
   logic [N_W-1:0]          n_new [3];
   logic [KIND_W-1:0]       kind;
   logic                    wr_inb, rd_inb;
   logic [AW-1:0]           waddr, raddr;
   logic [SR_W-1:0]         sr_sh, sr_trial;
   logic [N_W:0]            dv_sh;
   logic [DIST_W-1:0]       dist_sat;

   // Split the request payload.
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         o_req[j] = req_tdata[OFS_O + j*IN_W +: IN_W];
         v_req[j] = req_tdata[OFS_V + j*IN_W +: IN_W];
      end
   end

   // Distance numerator from the origin to the next boundary on each axis.
   always_comb begin
      logic signed [CELL_W+FRAC_BITS:0] bsc, osc, diff;
      for (int j = 0; j < 3; j++) begin
         bsc = {bnd_ff[j][CELL_W-1], bnd_ff[j], {FRAC_BITS{1'b0}}};
         osc = {{(CELL_W + FRAC_BITS + 1 - IN_W){1'b0}}, o_ff[j]};
         diff = neg_ff[j] ? osc - bsc : bsc - osc;
         n_new[j] = diff[N_W-1:0];
      end
   end

   // Operand selection of the two multipliers.
   always_comb begin
      ma = '0;
      mb = '0;
      mc = '0;
      md = '0;
      case (cmd.mul_sel)
         MUL_SQ01: begin
            ma = N_W'(d_ff[0]);
            mb = N_W'(d_ff[0]);
            mc = N_W'(d_ff[1]);
            md = N_W'(d_ff[1]);
         end
         MUL_SQ2: begin
            ma = N_W'(d_ff[2]);
            mb = N_W'(d_ff[2]);
         end
         MUL_P01: begin
            ma = n_ff[0];
            mb = N_W'(d_ff[1]);
            mc = n_ff[1];
            md = N_W'(d_ff[0]);
         end
         MUL_P02: begin
            ma = n_ff[0];
            mb = N_W'(d_ff[2]);
            mc = n_ff[2];
            md = N_W'(d_ff[0]);
         end
         MUL_P12: begin
            ma = n_ff[1];
            mb = N_W'(d_ff[2]);
            mc = n_ff[2];
            md = N_W'(d_ff[1]);
         end
         MUL_SHORT: begin
            ma = na;
            mb = N_W'(sd_ff);
            mc = ssum_ff;
            md = N_W'(da);
         end
         MUL_DIST: begin
            ma = sn_ff;
            mb = N_W'(len_ff);
         end
         default: ;
      endcase
   end

   // Crossing axis: smallest crossing among moving axes, lowest index on ties.
   always_comb begin
      if (mov_ff[0]) a_idx = 2'd0;
      else if (mov_ff[1]) a_idx = 2'd1;
      else a_idx = 2'd2;
      if (mov_ff[1] && a_idx == 2'd0 && !lt_ff[0] && !eq_ff[0]) a_idx = 2'd1;
      if (mov_ff[2]) begin
         if (a_idx == 2'd0 && !lt_ff[1] && !eq_ff[1]) a_idx = 2'd2;
         else if (a_idx == 2'd1 && !lt_ff[2] && !eq_ff[2]) a_idx = 2'd2;
      end
      case (a_idx)
         2'd0: begin
            tie[0] = 1'b1;
            tie[1] = eq_ff[0];
            tie[2] = eq_ff[1];
            na = n_ff[0];
            da = d_ff[0];
         end
         2'd1: begin
            tie[0] = eq_ff[0];
            tie[1] = 1'b1;
            tie[2] = eq_ff[2];
            na = n_ff[1];
            da = d_ff[1];
         end
         default: begin
            tie[0] = eq_ff[1];
            tie[1] = eq_ff[2];
            tie[2] = 1'b1;
            na = n_ff[2];
            da = d_ff[2];
         end
      endcase
   end

   // Next cell and boundary for one step.
   always_comb begin
      shortray = p_ff > q_ff;
      for (int j = 0; j < 3; j++) begin
         cell_upd[j] = cell_ff[j];
         bnd_upd[j]  = bnd_ff[j];
         if (mov_ff[j]) begin
            if (shortray) begin
               if (a_idx == 2'(j) || !neg_ff[j]) cell_upd[j] = bnd_ff[j] - CELL_W'(1);
               else cell_upd[j] = bnd_ff[j];
            end else if (tie[j]) begin
               if (a_idx == 2'(j) && neg_ff[j]) cell_upd[j] = bnd_ff[j] - CELL_W'(1);
               else cell_upd[j] = bnd_ff[j];
               bnd_upd[j] = neg_ff[j] ? bnd_ff[j] - CELL_W'(1) : bnd_ff[j] + CELL_W'(1);
            end else begin
               cell_upd[j] = neg_ff[j] ? bnd_ff[j] : bnd_ff[j] - CELL_W'(1);
            end
         end
      end
   end

   // Store addressing and grid bounds.
   always_comb begin
      wr_inb = (32'(wx_ff) < GRID_SIZE) && (32'(wy_ff) < GRID_SIZE) &&
               (32'(wz_ff) < GRID_SIZE);
      waddr  = {CW'(wx_ff), CW'(wy_ff), CW'(wz_ff)};
      rd_inb = 1'b1;
      for (int j = 0; j < 3; j++) begin
         if (cell_ff[j][CELL_W-1] || (cell_ff[j] >= $signed(CELL_W'(GRID_SIZE))))
            rd_inb = 1'b0;
      end
      raddr = {cell_ff[0][CW-1:0], cell_ff[1][CW-1:0], cell_ff[2][CW-1:0]};
      kind  = inb_ff ? rd_ff : KIND_EMPTY;
   end

   // Square root and divider step operands.
   always_comb begin
      sr_sh    = {srem_ff[SR_W-3:0], sq_ff[SQ_W-1 -: 2]};
      sr_trial = {1'b0, len_ff, 2'b01};
      dv_sh    = {drem_ff[N_W-1:0], dlo_ff[LEN_W-1]};
      dist_sat = dist_ff[LEN_W-1] ? '1 : dist_ff[DIST_W-1:0];
   end

   // Voxel store: clearing pass after reset, then single voxel writes.
   always_ff @(posedge clock) begin
      if (cmd.clear_step) mem_q[clr_addr_ff] <= KIND_EMPTY;
      else if (cmd.wr_voxel && wr_inb) mem_q[waddr] <= wkind_ff;
   end

   always_ff @(posedge clock) begin
      rd_ff  <= mem_q[raddr];
      inb_ff <= rd_inb;
   end

   always_ff @(posedge clock) begin
      if (reset) clr_addr_ff <= '0;
      else if (cmd.clear_step) clr_addr_ff <= clr_addr_ff + AW'(1);
   end

   // Shared multipliers, registered.
   always_ff @(posedge clock) begin
      p_ff <= ma * mb;
      q_ff <= mc * md;
   end

   // Request capture and march arithmetic.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= req_tuser;
         wx_ff    <= req_tdata[OFS_X +: COORD_W];
         wy_ff    <= req_tdata[OFS_Y +: COORD_W];
         wz_ff    <= req_tdata[OFS_Z +: COORD_W];
         wkind_ff <= req_tdata[OFS_KIND +: KIND_W];
         liq_ff   <= req_tdata[OFS_LIQ];
         lava_ff  <= 1'b0;
         hit_ff   <= 1'b0;
         dist_ff  <= '0;
         sn_ff    <= '0;
         sd_ff    <= IN_W'(1);
         ssum_ff  <= N_W'(1);
         end_ff   <= 1'b0;
         for (int j = 0; j < 3; j++) begin
            o_ff[j]   <= o_req[j];
            neg_ff[j] <= v_req[j][IN_W-1];
            mov_ff[j] <= v_req[j] != '0;
            d_ff[j]   <= v_req[j][IN_W-1] ? IN_W'(-v_req[j]) : v_req[j];
            cell_ff[j] <= CELL_W'(o_req[j][IN_W-1:FRAC_BITS]);
            if (v_req[j][IN_W-1])
               bnd_ff[j] <= CELL_W'(o_req[j][IN_W-1:FRAC_BITS]) +
                            CELL_W'(o_req[j][FRAC_BITS-1:0] != '0) - CELL_W'(1);
            else
               bnd_ff[j] <= CELL_W'(o_req[j][IN_W-1:FRAC_BITS]) + CELL_W'(1);
         end
      end

      // Sum of squares, then the integer square root two bits a step.
      if (cmd.sq_first) sq_ff <= SQ_W'(p_ff) + SQ_W'(q_ff);
      if (cmd.sq_add) begin
         sq_ff   <= sq_ff + SQ_W'(p_ff);
         len_ff  <= '0;
         srem_ff <= '0;
      end
      if (cmd.sqrt_step) begin
         sq_ff <= sq_ff << 2;
         if (sr_sh >= sr_trial) begin
            srem_ff <= sr_sh - sr_trial;
            len_ff  <= {len_ff[LEN_W-2:0], 1'b1};
         end else begin
            srem_ff <= sr_sh;
            len_ff  <= {len_ff[LEN_W-2:0], 1'b0};
         end
      end

      if (cmd.ncalc) begin
         for (int j = 0; j < 3; j++) n_ff[j] <= n_new[j];
      end

      // Store the crossing order of one axis pair.
      if (cmd.cmp_en) begin
         case (cmd.cmp_pair)
            PAIR_01: begin
               lt_ff[0] <= p_ff < q_ff;
               eq_ff[0] <= p_ff == q_ff;
            end
            PAIR_02: begin
               lt_ff[1] <= p_ff < q_ff;
               eq_ff[1] <= p_ff == q_ff;
            end
            default: begin
               lt_ff[2] <= p_ff < q_ff;
               eq_ff[2] <= p_ff == q_ff;
            end
         endcase
      end

      // Advance to the next cell; a short ray moves one full vector and ends.
      if (cmd.update) begin
         for (int j = 0; j < 3; j++) begin
            cell_ff[j] <= cell_upd[j];
            bnd_ff[j]  <= bnd_upd[j];
         end
         if (shortray) begin
            sn_ff  <= N_W'(1);
            sd_ff  <= IN_W'(1);
            end_ff <= 1'b1;
         end else begin
            sn_ff   <= na;
            sd_ff   <= da;
            ssum_ff <= na + N_W'(da);
            end_ff  <= na >= N_W'(da);
         end
      end

      if (cmd.examine) begin
         if (kind == KIND_WATER || kind == KIND_LAVA) liq_ff <= 1'b1;
         lava_ff <= kind == KIND_LAVA;
         if (kind == KIND_SOLID) hit_ff <= 1'b1;
      end

      // Hit distance len * sn / sd, one quotient bit a step.
      if (cmd.dist_len) dist_ff <= len_ff;
      if (cmd.div_init) begin
         drem_ff <= p_ff[P_W-1:LEN_W];
         dlo_ff  <= p_ff[LEN_W-1:0];
      end
      if (cmd.div_step) begin
         dlo_ff <= dlo_ff << 1;
         if (dv_sh >= (N_W+1)'(sd_ff)) begin
            drem_ff <= dv_sh - (N_W+1)'(sd_ff);
            dist_ff <= {dist_ff[LEN_W-2:0], 1'b1};
         end else begin
            drem_ff <= dv_sh;
            dist_ff <= {dist_ff[LEN_W-2:0], 1'b0};
         end
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.out_load) rsp_valid_ff <= 1'b1;
      else if (rsp_tready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         if (func_ff == FUNC_WRITE) begin
            rsp_user_ff <= 1'b0;
            rsp_data_ff <= '0;
         end else begin
            rsp_user_ff <= hit_ff;
            rsp_data_ff <= {7'b0, lava_ff, liq_ff, dist_sat,
                            hit_ff ? cell_ff[2][COORD_W-1:0] : COORD_W'(0),
                            hit_ff ? cell_ff[1][COORD_W-1:0] : COORD_W'(0),
                            hit_ff ? cell_ff[0][COORD_W-1:0] : COORD_W'(0)};
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // Status to the controller.
   always_comb begin
      sts.clr_last  = clr_addr_ff == '1;
      sts.is_march  = func_ff == FUNC_MARCH;
      sts.any_mov   = mov_ff[0] || mov_ff[1] || mov_ff[2];
      sts.solid     = kind == KIND_SOLID;
      sts.step_end  = end_ff;
      sts.hit       = hit_ff;
      sts.dist_full = sn_ff >= N_W'(sd_ff);
      sts.rsp_busy  = rsp_valid_ff && !rsp_tready;
   end

endmodule

@@ hdl/voxel_ray_march_unit.sv @@
// Top level of the voxel ray march unit: controller plus datapath.
// Depends on vrm_pkg, vrm_ctrl and vrm_datapath.
//
//  Channel   Direction  Handshake                  Payload
//  req_      in         req_tvalid / req_tready    tuser: func; tdata: voxel write or ray
//  rsp_      out        rsp_tvalid / rsp_tready    tuser: hit; tdata: cell, distance, flags
//
// One request is worked at a time. A voxel write passes the decode and write states. A march
// first finds the length (three squares, 22 square root steps), then for each cell visited
// compares crossings pair by pair on the two shared multipliers and reads the store, then
// runs the hit distance divider on a hit short of the full ray.
// After reset a clearing pass writes every store entry, 2^(3*ceil(log2(GRID_SIZE))) of
// them (262144 at the default size), before the first request is taken.
// The response register holds a result while the consumer stalls; a new result waits until
// that one has been handed over, and the next request is taken once the new result is loaded.
module voxel_ray_march_unit #(
   parameter int GRID_SIZE = vrm_pkg::GRID_SIZE_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // Fields from bit 0: cell_x, cell_y, cell_z, cell_kind, origin_x, origin_y,
   // origin_z, vec_x, vec_y, vec_z, liquid_in, zero fill.
   input  logic [vrm_pkg::REQ_DATA_W-1:0] req_tdata,
   // Field: func.
   input  logic                           req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // Fields from bit 0: hit_x, hit_y, hit_z, distance, in_liquid, in_lava, zero fill.
   output logic [vrm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // Field: hit.
   output logic                           rsp_tuser
);
   import vrm_pkg::*;

   cmd_type cmd;
   sts_type sts;

   vrm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   vrm_datapath #(
      .GRID_SIZE (GRID_SIZE)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // A result never overwrites one that is still stalled.
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_tvalid && !rsp_tready))
      else $error("response overwritten while stalled");

   // One request at a time: no request is taken right after another.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while busy");

   // A miss reports no hit cell.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[17:0] == '0))
      else $error("miss with nonzero cell");

endmodule
